// ===== design/fpa_pkg.sv =====
// Shared opcodes, item type and saturation helper for the fixed-point ALU.
`default_nettype none
package fpa_pkg;
	localparam logic [3:0] OP_ADD      = 4'd0;
	localparam logic [3:0] OP_SUB      = 4'd1;
	localparam logic [3:0] OP_MUL      = 4'd2;
	localparam logic [3:0] OP_DIV      = 4'd3;
	localparam logic [3:0] OP_INC      = 4'd4;
	localparam logic [3:0] OP_DEC      = 4'd5;
	localparam logic [3:0] OP_MIN      = 4'd6;
	localparam logic [3:0] OP_MAX      = 4'd7;
	localparam logic [3:0] OP_FROM_INT = 4'd8;
	localparam logic [3:0] OP_TO_INT   = 4'd9;

	localparam int IN_W  = 72;
	localparam int OUT_W = 40;

	typedef struct packed {
		logic [3:0]         op;
		logic signed [31:0] a;
		logic signed [31:0] b;
		logic               less;
		logic               equal;
		logic               greater;
	} item_t;

	// Turns a magnitude and a sign into a saturated 32-bit value; bit 32 is overflow.
	function automatic logic [32:0] sat_mag(input logic [64:0] q, input logic neg);
		logic [32:0] r;
		if (neg) begin
			if (q > 65'h0_8000_0000) r = {1'b1, 32'h8000_0000};
			else r = {1'b0, 32'd0 - q[31:0]};
		end else begin
			if (q > 65'h0_7FFF_FFFF) r = {1'b1, 32'h7FFF_FFFF};
			else r = {1'b0, q[31:0]};
		end
		return r;
	endfunction
endpackage
`default_nettype wire

// ===== design/fixed_point_alu.sv =====
// Fixed-point ALU (signed 32-bit raw values, FRAC_BITS fraction bits).
// Input beats arrive on s_tvalid/s_tready/s_tdata: op, operand_a, operand_b.
// Each beat yields one output beat on m_tvalid/m_tready/m_tdata with the
// result, the less/equal/greater compare flags, overflow and div_by_zero.
// Multiply and divide round to nearest, ties away from zero; results that
// leave the 32-bit range saturate and set overflow.
// Throughput is one beat per cycle while the receiver does not stall. An
// accepted beat passes one front register, the queue, two execute stages,
// one divider stage per quotient bit (32 + FRAC_BITS of them) and the
// output register. Every operation walks the full divider pipeline so
// results leave in order.
// A four-entry queue separates the front end from the pipeline; when the
// receiver stalls the pipeline freezes, the queue fills and then s_tready
// drops. Reset clears all valid flags and the queue; no beats are lost or
// invented across a stall.
`default_nettype none
module fixed_point_alu #(
	parameter int FRAC_BITS = 8
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     s_tvalid,
	output logic                          s_tready,
	input  wire logic [fpa_pkg::IN_W-1:0] s_tdata, // op[3:0], operand_a[35:4], operand_b[67:36]
	output logic                          m_tvalid,
	input  wire logic                     m_tready,
	// result[31:0], less[32], equal[33], greater[34], overflow[35], div_by_zero[36]
	output logic [fpa_pkg::OUT_W-1:0]     m_tdata
);
	import fpa_pkg::*;

	logic  push;
	item_t push_item;
	logic  fifo_full;
	logic  pop;
	logic  not_empty;
	item_t head;

	fpa_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.push      (push),
		.push_item (push_item),
		.fifo_full (fifo_full)
	);

	fpa_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (fifo_full),
		.pop       (pop),
		.not_empty (not_empty),
		.head      (head)
	);

	fpa_back #(.FRAC_BITS(FRAC_BITS)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.not_empty (not_empty),
		.head      (head),
		.pop       (pop),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

`ifndef SYNTHESIS
	a_flags_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> $onehot(m_tdata[34:32]))
		else $error("compare flags not one-hot");
	a_dz_no_ovf: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tdata[35] && m_tdata[36]))
		else $error("overflow together with divide by zero");
	a_dz_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[36]) |-> (m_tdata[31:0] == 32'd0))
		else $error("divide by zero with nonzero result");
`endif
endmodule
`default_nettype wire

// ===== design/fpa_front.sv =====
// Front end: takes input beats, compares the operands and registers the item.
`default_nettype none
module fpa_front (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      s_tvalid,
	output logic                           s_tready,
	input  wire logic [fpa_pkg::IN_W-1:0]  s_tdata, // op[3:0], operand_a[35:4], operand_b[67:36]
	output logic                           push,
	output fpa_pkg::item_t                 push_item,
	input  wire logic                      fifo_full
);
	import fpa_pkg::*;

	logic  valid_q;
	item_t item_q;
	item_t item_d;

	always_comb begin
		item_d.op      = s_tdata[3:0];
		item_d.a       = s_tdata[35:4];
		item_d.b       = s_tdata[67:36];
		item_d.less    = $signed(s_tdata[35:4]) < $signed(s_tdata[67:36]);
		item_d.equal   = s_tdata[35:4] == s_tdata[67:36];
		item_d.greater = $signed(s_tdata[35:4]) > $signed(s_tdata[67:36]);
	end

	assign push      = valid_q && !fifo_full;
	assign s_tready  = !valid_q || push;
	assign push_item = item_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (s_tready) begin
			valid_q <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_q <= item_d;
		end
	end
endmodule
`default_nettype wire

// ===== design/fpa_fifo.sv =====
// Four-entry queue between the front end and the execution pipeline.
`default_nettype none
module fpa_fifo (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire fpa_pkg::item_t push_item,
	output logic                full,
	input  wire logic           pop,
	output logic                not_empty,
	output fpa_pkg::item_t      head
);
	import fpa_pkg::*;

	item_t      mem_q [0:3];
	logic [1:0] wr_q;
	logic [1:0] rd_q;
	logic [2:0] cnt_q;

	assign full      = cnt_q == 3'd4;
	assign not_empty = cnt_q != 3'd0;
	assign head      = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 2'd0;
			rd_q  <= 2'd0;
			cnt_q <= 3'd0;
		end else begin
			if (push) wr_q <= wr_q + 2'd1;
			if (pop) rd_q <= rd_q + 2'd1;
			if (push && !pop) cnt_q <= cnt_q + 3'd1;
			else if (pop && !push) cnt_q <= cnt_q - 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_item;
		end
	end
endmodule
`default_nettype wire

// ===== design/fpa_back.sv =====
// Execution pipeline: simple ops, multiply rounding, bit-per-stage divider, output register.
`default_nettype none
module fpa_back #(
	parameter int FRAC_BITS = 8
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      not_empty,
	input  wire fpa_pkg::item_t            head,
	output logic                           pop,
	output logic                           m_tvalid,
	input  wire logic                      m_tready,
	output logic [fpa_pkg::OUT_W-1:0]      m_tdata
);
	import fpa_pkg::*;

	localparam int NW = 32 + FRAC_BITS;

	typedef struct packed {
		logic [3:0]  op;
		logic        less;
		logic        equal;
		logic        greater;
		logic [31:0] res;
		logic        ovf;
		logic        dz;
		logic        neg;
		logic [31:0] den;
	} carry_t;

	logic en;
	assign en  = !m_tvalid || m_tready;
	assign pop = en && not_empty;

	// Stage 1: simple operations, multiplier, divider operands.
	logic               v_s1;
	carry_t             c_s1;
	logic signed [63:0] prod_s1;
	logic [NW-1:0]      num_s1;

	logic signed [32:0] sum;
	logic signed [63:0] wide;
	logic [31:0]        mag_a;
	carry_t             c_d;

	always_comb begin
		mag_a     = head.a[31] ? 32'd0 - head.a : head.a;
		sum       = 33'sd0;
		wide      = 64'sd0;
		c_d.op    = head.op;
		c_d.less  = head.less;
		c_d.equal = head.equal;
		c_d.greater = head.greater;
		c_d.res   = 32'd0;
		c_d.ovf   = 1'b0;
		c_d.dz    = (head.op == OP_DIV) && (head.b == 32'sd0);
		c_d.neg   = head.a[31] ^ head.b[31];
		c_d.den   = head.b[31] ? 32'd0 - head.b : head.b;
		unique case (head.op) inside
			OP_ADD, OP_SUB, OP_INC, OP_DEC: begin
				case (head.op)
					OP_ADD:  sum = 33'(head.a) + 33'(head.b);
					OP_SUB:  sum = 33'(head.a) - 33'(head.b);
					OP_INC:  sum = 33'(head.a) + 33'sd1;
					default: sum = 33'(head.a) - 33'sd1;
				endcase
				if (sum[32] != sum[31]) begin
					c_d.ovf = 1'b1;
					c_d.res = sum[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
				end else begin
					c_d.res = sum[31:0];
				end
			end
			OP_MIN: c_d.res = head.less ? head.a : head.b;
			OP_MAX: c_d.res = head.greater ? head.a : head.b;
			OP_FROM_INT: begin
				wide = 64'(head.a) <<< FRAC_BITS;
				if (wide > 64'sh7FFF_FFFF) begin
					c_d.ovf = 1'b1;
					c_d.res = 32'h7FFF_FFFF;
				end else if (wide < -64'sh8000_0000) begin
					c_d.ovf = 1'b1;
					c_d.res = 32'h8000_0000;
				end else begin
					c_d.res = wide[31:0];
				end
			end
			OP_TO_INT: c_d.res = head.a >>> FRAC_BITS;
			default: c_d.res = 32'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= not_empty;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			c_s1    <= c_d;
			prod_s1 <= 64'(head.a) * 64'(head.b);
			num_s1  <= {mag_a, {FRAC_BITS{1'b0}}};
		end
	end

	// Stage 2: round and saturate the product.
	logic          v_s2;
	carry_t        c_s2;
	logic [NW-1:0] num_s2;
	logic [63:0]   pmag;
	logic [63:0]   pq;
	logic [32:0]   psat;
	carry_t        c_mul;

	always_comb begin
		pmag  = prod_s1[63] ? 64'd0 - prod_s1 : prod_s1;
		pq    = (pmag + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
		psat  = sat_mag({1'b0, pq}, prod_s1[63]);
		c_mul = c_s1;
		if (c_s1.op == OP_MUL) begin
			c_mul.res = psat[31:0];
			c_mul.ovf = psat[32];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			c_s2   <= c_mul;
			num_s2 <= num_s1;
		end
	end

	// Divider stages: one quotient bit per stage, restoring.
	logic          v_s3    [0:NW];
	carry_t        c_s3    [0:NW];
	logic [NW-1:0] num_s3  [0:NW];
	logic [31:0]   rem_s3  [0:NW];
	logic [NW-1:0] quot_s3 [0:NW];

	assign v_s3[0]    = v_s2;
	assign c_s3[0]    = c_s2;
	assign num_s3[0]  = num_s2;
	assign rem_s3[0]  = 32'd0;
	assign quot_s3[0] = '0;

	for (genvar k = 0; k < NW; k++) begin : g_div
		logic [32:0] trial;
		logic        fits;
		assign trial = {rem_s3[k], num_s3[k][NW-1]};
		assign fits  = trial >= {1'b0, c_s3[k].den};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s3[k+1] <= 1'b0;
			end else if (en) begin
				v_s3[k+1] <= v_s3[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				c_s3[k+1]    <= c_s3[k];
				num_s3[k+1]  <= num_s3[k] << 1;
				rem_s3[k+1]  <= fits ? 32'(trial - {1'b0, c_s3[k].den}) : trial[31:0];
				quot_s3[k+1] <= {quot_s3[k][NW-2:0], fits};
			end
		end
	end

	// Output register: divide rounding and saturation.
	carry_t      cf;
	logic [NW:0] qr;
	logic [32:0] dsat;
	logic        valid_q;
	logic [OUT_W-1:0] data_q;
	logic [31:0] res_f;
	logic        ovf_f;

	always_comb begin
		cf    = c_s3[NW];
		qr    = {1'b0, quot_s3[NW]} +
			(({rem_s3[NW], 1'b0} >= {1'b0, cf.den}) ? (NW+1)'(1) : (NW+1)'(0));
		dsat  = sat_mag({{(64-NW){1'b0}}, qr}, cf.neg);
		res_f = cf.res;
		ovf_f = cf.ovf;
		if (cf.op == OP_DIV) begin
			if (cf.dz) begin
				res_f = 32'd0;
				ovf_f = 1'b0;
			end else begin
				res_f = dsat[31:0];
				ovf_f = dsat[32];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= v_s3[NW];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_q <= {3'd0, cf.dz, ovf_f, cf.greater, cf.equal, cf.less, res_f};
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = data_q;
endmodule
`default_nettype wire

// ===== tb/fpa_checker.sv =====
// Checker for the fixed-point ALU: predicts every output beat, compares it and reports mismatches field by field.
module fpa_checker #(
	parameter int FRAC_BITS = 8
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     s_tvalid,
	input  wire logic                     s_tready,
	input  wire logic [fpa_pkg::IN_W-1:0] s_tdata,
	input  wire logic                     m_tvalid,
	input  wire logic                     m_tready,
	input  wire logic [fpa_pkg::OUT_W-1:0] m_tdata,
	output int                            errors,
	output int                            pending
);
	timeunit 1ns;
	timeprecision 1ps;
	import fpa_pkg::*;

	typedef struct packed {
		logic        div_by_zero;
		logic        overflow;
		logic        greater;
		logic        equal;
		logic        less;
		logic [31:0] result;
	} alu_out_t;

	alu_out_t expected_q[$];

	localparam longint MAX32 = 64'sd2147483647;
	localparam longint MIN32 = -64'sd2147483648;

	function automatic longint clamp32(input longint v, inout logic ovf);
		if (v > MAX32) begin
			ovf = 1'b1;
			return MAX32;
		end
		if (v < MIN32) begin
			ovf = 1'b1;
			return MIN32;
		end
		return v;
	endfunction

	function automatic alu_out_t compute_alu(input logic [3:0] op, input logic signed [31:0] ra,
			input logic signed [31:0] rb);
		alu_out_t o;
		longint a, b, r, p, mag, num, den, q, rem;
		logic ovf, neg;
		a = ra;
		b = rb;
		r = 0;
		ovf = 1'b0;
		o = '0;
		case (op)
			OP_ADD: r = clamp32(a + b, ovf);
			OP_SUB: r = clamp32(a - b, ovf);
			OP_MUL: begin
				p = a * b;
				neg = p < 0;
				mag = neg ? -p : p;
				q = (mag + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
				r = clamp32(neg ? -q : q, ovf);
			end
			OP_DIV: begin
				if (b == 0) begin
					o.div_by_zero = 1'b1;
				end else begin
					neg = (a < 0) != (b < 0);
					num = (a < 0 ? -a : a) <<< FRAC_BITS;
					den = b < 0 ? -b : b;
					q = num / den;
					rem = num % den;
					if (rem >= den - rem) q++;
					r = clamp32(neg ? -q : q, ovf);
				end
			end
			OP_INC: r = clamp32(a + 1, ovf);
			OP_DEC: r = clamp32(a - 1, ovf);
			OP_MIN: r = a < b ? a : b;
			OP_MAX: r = a > b ? a : b;
			OP_FROM_INT: r = clamp32(a * (64'sd1 <<< FRAC_BITS), ovf);
			OP_TO_INT: r = a >>> FRAC_BITS;
			default: r = 0;
		endcase
		o.result = r[31:0];
		o.less = a < b;
		o.equal = a == b;
		o.greater = a > b;
		o.overflow = ovf;
		return o;
	endfunction

	assign pending = expected_q.size();

	always @(posedge clk) begin
		alu_out_t got, want;
		if (arst_n) begin
			if (s_tvalid && s_tready)
				expected_q.push_back(compute_alu(s_tdata[3:0], s_tdata[35:4], s_tdata[67:36]));
			if (m_tvalid && m_tready) begin
				got = m_tdata[36:0];
				if (expected_q.size() == 0) begin
					errors++;
					if (errors <= 10) $display("Unexpected output beat %h", got);
				end else begin
					want = expected_q.pop_front();
					if (got !== want) begin
						errors++;
						if (errors <= 10)
							$display("Mismatch: result %h/%h lt %b/%b eq %b/%b gt %b/%b ovf %b/%b dz %b/%b (exp/got)",
								want.result, got.result, want.less, got.less, want.equal, got.equal,
								want.greater, got.greater, want.overflow, got.overflow,
								want.div_by_zero, got.div_by_zero);
					end
				end
			end
		end
	end

	initial errors = 0;
endmodule

// ===== tb/tb_top.sv =====
// Top of the fixed-point ALU testbench: clock, reset, stimulus and verdict.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import fpa_pkg::*;

	localparam int FRAC_BITS = 8;
	localparam int LATENCY = 36 + FRAC_BITS;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [IN_W-1:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OUT_W-1:0] m_tdata;
	int errors, pending;
	int send_idle_pct = 0, recv_stall_pct = 0;

	fixed_point_alu #(.FRAC_BITS(FRAC_BITS)) DUT (.*);
	fpa_checker #(.FRAC_BITS(FRAC_BITS)) u_checker (.*);

	initial begin
		forever #4 clk = ~clk;
	end

	initial begin
		#50ms;
		$display("Verification failed");
		$finish;
	end

	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	function automatic logic [31:0] pick_operand();
		case ($urandom_range(7))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return 32'd0;
			3: return $urandom_range(2047) - 1024;
			4: return $urandom_range(32'hFFFF) - 32'h8000;
			5: return $urandom_range(32'h00FF_FFFF) - 32'h0080_0000;
			default: return $urandom;
		endcase
	endfunction

	// Holds one beat on the slave side until the block takes it.
	task automatic send_beat(input logic [3:0] op, input logic [31:0] a, input logic [31:0] b);
		while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {4'd0, b, a, op};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (pending != 0) @(posedge clk);
	endtask

	initial begin
		logic [3:0] op;
		logic [3:0] all_ops[10] = '{OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_INC, OP_DEC,
			OP_MIN, OP_MAX, OP_FROM_INT, OP_TO_INT};
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: every operation at the range edges, divide by zero, ties,
		// and two of the undefined opcodes.
		foreach (all_ops[i]) send_beat(all_ops[i], 32'h7FFF_FFFF, 32'h8000_0000);
		send_beat(OP_DIV, 32'h0000_0100, 32'd0);
		send_beat(OP_DIV, 32'h8000_0000, 32'hFFFF_FFFF);
		send_beat(OP_MUL, 32'h8000_0000, 32'h8000_0000);
		send_beat(OP_MUL, 32'h0000_0001, 32'h0000_0080);
		send_beat(OP_MUL, 32'hFFFF_FFFF, 32'h0000_0080);
		send_beat(OP_DIV, 32'h0000_0001, 32'h0000_0200);
		send_beat(OP_INC, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		send_beat(OP_DEC, 32'h8000_0000, 32'h8000_0000);
		send_beat(OP_TO_INT, 32'hFFFF_FF01, 32'd5);
		send_beat(4'd10, 32'd7, 32'd7);
		send_beat(4'd15, 32'hFFFF_FFFF, 32'h0);
		drain();

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin send_idle_pct = 0; recv_stall_pct = 0; end
				1: begin send_idle_pct = 48; recv_stall_pct = 0; end
				2: begin send_idle_pct = 0; recv_stall_pct = 48; end
				default: begin send_idle_pct = 36; recv_stall_pct = 36; end
			endcase
			for (int n = 0; n < 300; n++) begin
				op = ($urandom_range(29) == 0) ? 4'($urandom_range(15, 10))
					: 4'($urandom_range(9));
				send_beat(op, pick_operand(), pick_operand());
			end
			drain();
		end

		send_idle_pct = 0;
		recv_stall_pct = 0;
		repeat (LATENCY + 20) @(posedge clk);
		if (errors == 0 && pending == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end
endmodule
